// ===== hw/rtl/yuv2rgb_pkg.sv =====
package yuv2rgb_pkg;

    // Offset of the chroma bytes in offset-binary form.
    localparam int unsigned CHROMA_BIAS = 128;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SUM_W  = 11;   // luma plus widest chroma term, signed
    localparam int unsigned BTERM_W = 10;  // -258..255
    localparam int unsigned GTERM_W = 9;   // -144..142
    localparam int unsigned RTERM_W = 9;   // -192..190

    localparam int unsigned BLUE_SHIFT  = 6;
    localparam int unsigned GREEN_SHIFT = 3;
    localparam int unsigned RED_SHIFT   = 1;

    typedef struct packed {
        logic signed [BTERM_W-1:0] blue;
        logic signed [GTERM_W-1:0] green;
        logic signed [RTERM_W-1:0] red;
    } t_chroma_terms;

endpackage

// ===== hw/rtl/yuv2rgb_chroma.sv =====
module yuv2rgb_chroma (
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_u,
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_v,
    output yuv2rgb_pkg::t_chroma_terms    o_terms
);

    // Remove the bias: flipping the top bit of an offset-binary byte gives two's complement.
    logic signed [7:0]  cu;
    logic signed [7:0]  cv;
    logic signed [15:0] blue_sum;   // 129*U
    logic signed [11:0] green_sum;  // 3*U + 6*V
    logic signed [9:0]  red_sum;    // 3*V
    logic signed [15:0] cu16;
    logic signed [11:0] cu12;
    logic signed [11:0] cv12;
    logic signed [9:0]  cv10;
    logic signed [15:0] blue_shr;
    logic signed [11:0] green_shr;
    logic signed [9:0]  red_shr;

    assign cu = signed'({~i_u[7], i_u[6:0]});
    assign cv = signed'({~i_v[7], i_v[6:0]});

    assign cu16 = 16'(cu);
    assign cu12 = 12'(cu);
    assign cv12 = 12'(cv);
    assign cv10 = 10'(cv);

    assign blue_sum  = (cu16 <<< 7) + cu16;
    assign green_sum = (cu12 <<< 1) + cu12 + (cv12 <<< 2) + (cv12 <<< 1);
    assign red_sum   = (cv10 <<< 1) + cv10;

    // Arithmetic shifts floor toward minus infinity.
    assign blue_shr  = blue_sum  >>> yuv2rgb_pkg::BLUE_SHIFT;
    assign green_shr = green_sum >>> yuv2rgb_pkg::GREEN_SHIFT;
    assign red_shr   = red_sum   >>> yuv2rgb_pkg::RED_SHIFT;

    assign o_terms.blue  = blue_shr[yuv2rgb_pkg::BTERM_W-1:0];
    assign o_terms.green = green_shr[yuv2rgb_pkg::GTERM_W-1:0];
    assign o_terms.red   = red_shr[yuv2rgb_pkg::RTERM_W-1:0];

endmodule

// ===== hw/rtl/yuv2rgb_pixel.sv =====
module yuv2rgb_pixel (
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_luma,
    input  yuv2rgb_pkg::t_chroma_terms    i_terms,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_red,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_green,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_blue
);

    logic signed [yuv2rgb_pkg::SUM_W-1:0] luma_s;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] red_s;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] green_s;
    logic signed [yuv2rgb_pkg::SUM_W-1:0] blue_s;

    // Saturate a signed sum to one byte.
    function automatic logic [yuv2rgb_pkg::PIX_W-1:0] clamp_byte(
        input logic signed [yuv2rgb_pkg::SUM_W-1:0] x
    );
        logic [yuv2rgb_pkg::PIX_W-1:0] r;
        if (x[yuv2rgb_pkg::SUM_W-1]) begin
            r = '0;
        end else if (|x[yuv2rgb_pkg::SUM_W-2:yuv2rgb_pkg::PIX_W]) begin
            r = '1;
        end else begin
            r = x[yuv2rgb_pkg::PIX_W-1:0];
        end
        return r;
    endfunction

    assign luma_s  = signed'(yuv2rgb_pkg::SUM_W'(i_luma));
    assign red_s   = luma_s + yuv2rgb_pkg::SUM_W'(i_terms.red);
    assign green_s = luma_s - yuv2rgb_pkg::SUM_W'(i_terms.green);
    assign blue_s  = luma_s + yuv2rgb_pkg::SUM_W'(i_terms.blue);

    assign o_red   = clamp_byte(red_s);
    assign o_green = clamp_byte(green_s);
    assign o_blue  = clamp_byte(blue_s);

endmodule

// ===== hw/rtl/yuyv_to_rgb_converter.sv =====
// YUYV 4:2:2 macropixel to two RGB888 pixels.
// A request passes through the input register, then the result register, before it reaches o_done.
// Throughput: one request per cycle; o_busy stays low, the receiver cannot stall.
// Each result is shown for one cycle with o_done high.
// Reset (i_rst_n low, synchronous) clears only the valid flags; payload registers are not reset.
// The chroma terms and the add/clamp are shallow shift-add logic between the two registers.
module yuyv_to_rgb_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_luma_first,
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_chroma_blue,
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_luma_second,
    input  logic [yuv2rgb_pkg::PIX_W-1:0] i_chroma_red,
    output logic                          o_done,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_red_first,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_green_first,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_blue_first,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_red_second,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_green_second,
    output logic [yuv2rgb_pkg::PIX_W-1:0] o_blue_second
);

    // Input register stage.
    logic                          r_in_valid;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_y0;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_u;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_y1;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_v;

    // Result register stage.
    logic                          r_done;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_red0;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_green0;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_blue0;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_red1;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_green1;
    logic [yuv2rgb_pkg::PIX_W-1:0] r_blue1;

    logic                          accept;
    yuv2rgb_pkg::t_chroma_terms    terms;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_red0;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_green0;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_blue0;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_red1;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_green1;
    logic [yuv2rgb_pkg::PIX_W-1:0] n_blue1;

    // The datapath is fully pipelined, so a request is taken every cycle.
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // Capture the request; hold payload when nothing arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_y0 <= i_luma_first;
            r_u  <= i_chroma_blue;
            r_y1 <= i_luma_second;
            r_v  <= i_chroma_red;
        end
    end

    // Shared chroma terms for both pixels of the macropixel.
    yuv2rgb_chroma u_chroma (
        .i_u     (r_u),
        .i_v     (r_v),
        .o_terms (terms)
    );

    // Add the terms to each luma and saturate.
    yuv2rgb_pixel u_pixel_first (
        .i_luma  (r_y0),
        .i_terms (terms),
        .o_red   (n_red0),
        .o_green (n_green0),
        .o_blue  (n_blue0)
    );

    yuv2rgb_pixel u_pixel_second (
        .i_luma  (r_y1),
        .i_terms (terms),
        .o_red   (n_red1),
        .o_green (n_green1),
        .o_blue  (n_blue1)
    );

    // Register the result; o_done pulses for exactly one cycle per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
        if (r_in_valid) begin
            r_red0   <= n_red0;
            r_green0 <= n_green0;
            r_blue0  <= n_blue0;
            r_red1   <= n_red1;
            r_green1 <= n_green1;
            r_blue1  <= n_blue1;
        end
    end

    assign o_done         = r_done;
    assign o_red_first    = r_red0;
    assign o_green_first  = r_green0;
    assign o_blue_first   = r_blue0;
    assign o_red_second   = r_red1;
    assign o_green_second = r_green1;
    assign o_blue_second  = r_blue1;

endmodule
